FILE: src/block_intensity_detail_transfer_assert.svh
// ----------------------------------------------------------------------------
// block intensity detail transfer assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef BLOCK_INTENSITY_DETAIL_TRANSFER_ASSERT_SVH
`define BLOCK_INTENSITY_DETAIL_TRANSFER_ASSERT_SVH

`ifndef SYNTHESIS

// check that is switched off while reset is asserted
`define BIDT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check that also holds while reset is asserted
`define BIDT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BIDT_ASSERT(lbl, clk, rstn, prop, msg)
`define BIDT_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

FILE: src/bidt_pkg.sv
// ----------------------------------------------------------------------------
// bidt_pkg
// shared widths, constants and types of the block intensity detail transfer
// ----------------------------------------------------------------------------
package bidt_pkg;

  localparam int PIX_W         = 16;  // pixel field width
  localparam int SENS_W        = 16;  // sensitivity register width
  localparam int RATIO_CFG_W   = 4;   // ratio register width
  localparam int CFG_IDX_W     = 2;   // configuration index width
  localparam int CFG_DATA_W    = 16;  // configuration data width
  localparam int MAX_RATIO_DEF = 8;
  localparam int PIXEL_BITS    = 16;

  // saturation value of an output pixel
  localparam logic [PIX_W-1:0] PIX_MAX =
    (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << PIXEL_BITS) - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATIO_W = 2'd0,
    REG_RATIO_H = 2'd1,
    REG_SENS    = 2'd2
  } cfg_reg_e;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

FILE: src/bidt_ram.sv
// ----------------------------------------------------------------------------
// bidt_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bidt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bidt_div.sv
// ----------------------------------------------------------------------------
// bidt_div
// shift-subtract divider with rounding-free pixel-width quotient and
// overflow detection in its first step
// ----------------------------------------------------------------------------
`include "block_intensity_detail_transfer_assert.svh"

module bidt_div #(
  parameter int N_W = 57,
  parameter int D_W = 39
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [N_W-1:0]          num_i,
  input  logic [D_W-1:0]          den_i,
  output bidt_pkg::div_stat_t     stat_o,
  output logic [bidt_pkg::PIX_W-1:0] quo_o
);

  import bidt_pkg::*;

  localparam int CW = $clog2(PIX_W + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [N_W-1:0] rem_q, rem_d;
  logic [N_W-1:0] dsh_q, dsh_d;
  logic [PIX_W-1:0] quo_q, quo_d;
  logic          ovf_q, ovf_d;
  logic          ge;

  assign ge = (rem_q >= dsh_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i;
      dsh_d  = N_W'(den_i) << PIX_W;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        // quotient would not fit the pixel width
        if (ge) begin
          ovf_d  = 1'b1;
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          dsh_d = dsh_q >> 1;
          cnt_d = cnt_q + CW'(1);
        end
      end else begin
        if (ge) begin
          rem_d = rem_q - dsh_q;
        end
        quo_d = {quo_q[PIX_W-2:0], ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(PIX_W)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;
  assign quo_o       = quo_q;

  `BIDT_ASSERT(a_div_start_idle, clk_i, rst_ni, start_i |-> !busy_q, "divider started while busy")
  `BIDT_ASSERT(a_div_done_idle, clk_i, rst_ni, done_q |-> !busy_q, "divider done while busy")
  `BIDT_ASSERT_NR(a_div_cnt_range, clk_i, busy_q |-> (cnt_q <= CW'(PIX_W)), "divider step overrun")

endmodule

FILE: src/block_intensity_detail_transfer.sv
// ----------------------------------------------------------------------------
// block_intensity_detail_transfer
// buffers one high-res block, then emits low*(1+256*(high-mean)/(mean*sens))
// per pixel, rounded, clamped at zero and saturated
// ----------------------------------------------------------------------------
// loading: one input transfer per cycle, no result until the last pixel is in
// emitting: each output pixel waits for the 17-step divider; the divider is
//   skipped when the block sum is zero (low passes through) or the value clamps to zero
// input is stalled while a block is emitted; the last result may wait in the
//   output register while the next block loads
// reset: async active low, clears fill count, sum and ratios (2, 2, sens 256)
`include "block_intensity_detail_transfer_assert.svh"

module block_intensity_detail_transfer #(
  parameter int MAX_RATIO = bidt_pkg::MAX_RATIO_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [2*bidt_pkg::PIX_W-1:0]    s_axis_tdata,  // high_pixel, low_pixel
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bidt_pkg::PIX_W-1:0]      m_axis_tdata,  // out_pixel
  output logic                            m_axis_tlast,  // last_of_block
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bidt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bidt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import bidt_pkg::*;

  localparam int BUF_DEPTH = MAX_RATIO * MAX_RATIO;
  localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int RATIO_W   = $clog2(MAX_RATIO + 1);
  localparam int SUM_W     = PIX_W + CNT_W;
  localparam int DEN_W     = SUM_W + SENS_W;
  localparam int INNER_W   = DEN_W + 2;
  localparam int NUM_W     = PIX_W + INNER_W - 1;
  localparam int N_W       = NUM_W + 2;
  localparam int D_W       = DEN_W + 1;

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_RD    = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_INNER = 8'b0000_1000,
    ST_NUM   = 8'b0001_0000,
    ST_START = 8'b0010_0000,
    ST_DIVW  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [RATIO_CFG_W-1:0] ratio_w_q, ratio_w_d;
  logic [RATIO_CFG_W-1:0] ratio_h_q, ratio_h_d;
  logic [SENS_W-1:0]      sens_q, sens_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [CNT_W-1:0]       k_q, k_d;
  logic                   m_valid_q, m_valid_d;

  logic [PIX_W-1:0]          low_q, low_d;
  logic [SUM_W-1:0]          hn_q, hn_d;
  logic [DEN_W-1:0]          den_q, den_d;
  logic signed [INNER_W-1:0] inner_q, inner_d;
  logic [NUM_W-1:0]          num_q, num_d;
  logic [PIX_W-1:0]          res_q, res_d;
  logic [PIX_W-1:0]          out_pix_q, out_pix_d;
  logic                      out_last_q, out_last_d;

  logic [PIX_W-1:0]          high_pix, low_pix;
  logic [RATIO_W-1:0]        rw_eff, rh_eff;
  logic [2*RATIO_W-1:0]      len_full;
  logic [CNT_W-1:0]          blk_len, fill_inc;
  logic                      in_go, blk_end, out_go, is_last;
  logic [SENS_W-1:0]         sens_eff;
  logic signed [INNER_W-1:0] diff_ext;
  logic                      inner_pos;
  logic [PIX_W-1:0]          ram_rdata;
  logic                      div_start;
  logic [N_W-1:0]            div_num;
  logic [D_W-1:0]            div_den;
  div_stat_t                 div_st;
  logic [PIX_W-1:0]          div_quo;

  assign high_pix = s_axis_tdata[PIX_W-1:0];
  assign low_pix  = s_axis_tdata[2*PIX_W-1:PIX_W];

  // ratio of zero acts as one, above MAX_RATIO as MAX_RATIO
  always_comb begin
    if (ratio_w_q == '0) begin
      rw_eff = RATIO_W'(1);
    end else if (int'(ratio_w_q) > MAX_RATIO) begin
      rw_eff = RATIO_W'(MAX_RATIO);
    end else begin
      rw_eff = RATIO_W'(ratio_w_q);
    end
    if (ratio_h_q == '0) begin
      rh_eff = RATIO_W'(1);
    end else if (int'(ratio_h_q) > MAX_RATIO) begin
      rh_eff = RATIO_W'(MAX_RATIO);
    end else begin
      rh_eff = RATIO_W'(ratio_h_q);
    end
  end

  assign len_full = (2*RATIO_W)'(rw_eff) * (2*RATIO_W)'(rh_eff);
  assign blk_len  = CNT_W'(len_full);
  assign fill_inc = fill_q + CNT_W'(1);
  assign blk_end  = (fill_inc >= blk_len) || (fill_inc == CNT_W'(BUF_DEPTH));

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_go         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign sens_eff  = (sens_q == '0) ? SENS_W'(1) : sens_q;
  assign diff_ext  = INNER_W'($signed({1'b0, hn_q}) - $signed({1'b0, sum_q}));
  assign inner_pos = !inner_q[INNER_W-1] && (inner_q != '0);
  assign is_last   = ((k_q + CNT_W'(1)) == fill_q);
  assign out_go    = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // rounded quotient: (2*num + den) / (2*den)
  assign div_start = (state_q == ST_START);
  assign div_num   = (N_W'(num_q) << 1) + N_W'(den_q);
  assign div_den   = D_W'(den_q) << 1;

  always_comb begin
    state_d    = state_q;
    ratio_w_d  = ratio_w_q;
    ratio_h_d  = ratio_h_q;
    sens_d     = sens_q;
    fill_d     = fill_q;
    sum_d      = sum_q;
    k_d        = k_q;
    m_valid_d  = m_valid_q;
    low_d      = low_q;
    hn_d       = hn_q;
    den_d      = den_q;
    inner_d    = inner_q;
    num_d      = num_q;
    res_d      = res_q;
    out_pix_d  = out_pix_q;
    out_last_d = out_last_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RATIO_W: ratio_w_d = cfg_data_i[RATIO_CFG_W-1:0];
        REG_RATIO_H: ratio_h_d = cfg_data_i[RATIO_CFG_W-1:0];
        REG_SENS:    sens_d    = cfg_data_i[SENS_W-1:0];
        default: ;
      endcase
    end

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (in_go) begin
          sum_d  = sum_q + SUM_W'(high_pix);
          fill_d = fill_inc;
          if (blk_end) begin
            low_d   = low_pix;
            k_d     = '0;
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        hn_d    = SUM_W'(ram_rdata) * SUM_W'(fill_q);
        den_d   = DEN_W'(sum_q) * DEN_W'(sens_eff);
        state_d = ST_INNER;
      end
      ST_INNER: begin
        inner_d = $signed({2'b00, den_q}) + (diff_ext <<< 8);
        state_d = ST_NUM;
      end
      ST_NUM: begin
        num_d = NUM_W'(low_q) * NUM_W'(inner_q[INNER_W-2:0]);
        if (sum_q == '0) begin
          res_d   = (low_q > PIX_MAX) ? PIX_MAX : low_q;
          state_d = ST_OUT;
        end else if (!inner_pos) begin
          res_d   = '0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        state_d = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_st.done) begin
          res_d   = (div_st.ovf || (div_quo > PIX_MAX)) ? PIX_MAX : div_quo;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_go) begin
          m_valid_d  = 1'b1;
          out_pix_d  = res_q;
          out_last_d = is_last;
          if (is_last) begin
            fill_d  = '0;
            sum_d   = '0;
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + CNT_W'(1);
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      ratio_w_q <= RATIO_CFG_W'(2);
      ratio_h_q <= RATIO_CFG_W'(2);
      sens_q    <= SENS_W'(256);
      fill_q    <= '0;
      sum_q     <= '0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ratio_w_q <= ratio_w_d;
      ratio_h_q <= ratio_h_d;
      sens_q    <= sens_d;
      fill_q    <= fill_d;
      sum_q     <= sum_d;
      k_q       <= k_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q      <= low_d;
    hn_q       <= hn_d;
    den_q      <= den_d;
    inner_q    <= inner_d;
    num_q      <= num_d;
    res_q      <= res_d;
    out_pix_q  <= out_pix_d;
    out_last_q <= out_last_d;
  end

  bidt_ram #(
    .WIDTH (PIX_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (in_go),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (high_pix),
    .re_i    (state_q == ST_RD),
    .raddr_i (k_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  bidt_div #(
    .N_W (N_W),
    .D_W (D_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_st),
    .quo_o   (div_quo)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

  `BIDT_ASSERT(a_empty_sum, clk_i, rst_ni, (fill_q == '0) |-> (sum_q == '0), "sum without pixels")
  `BIDT_ASSERT(a_fill_room, clk_i, rst_ni, s_axis_tready |-> (fill_q < CNT_W'(BUF_DEPTH)), "buffer full while loading")
  `BIDT_ASSERT(a_emit_index, clk_i, rst_ni, (state_q != ST_LOAD) |-> (k_q < fill_q), "emit index past fill")
  `BIDT_ASSERT(a_div_done_wait, clk_i, rst_ni, div_st.done |-> (state_q == ST_DIVW), "divider result unexpected")
  `BIDT_ASSERT(a_block_close, clk_i, rst_ni, (out_go && is_last) |=> ((state_q == ST_LOAD) && (fill_q == '0)), "block not closed")

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives pixel blocks through block_intensity_detail_transfer under random
// source gaps and sink stalls, predicts every enhanced pixel and checks each
// output transfer in order
// ----------------------------------------------------------------------------
module testbench;
  import bidt_pkg::*;

  localparam int          BUF_DEPTH     = MAX_RATIO_DEF * MAX_RATIO_DEF;
  localparam int          SETTLE_CYCLES = 30;
  localparam int          RANDOM_ITEMS  = 400;
  localparam int unsigned CYCLE_LIMIT   = 500_000;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } enh_pix_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_THROTTLE} sink_mode_e;
  typedef enum int {BLK_NOISE, BLK_FLAT, BLK_ZERO, BLK_EDGES, BLK_DARK} blk_kind_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*PIX_W-1:0]    s_axis_tdata = '0;  // high_pixel, low_pixel
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [PIX_W-1:0]      m_axis_tdata;       // out_pixel
  logic                  m_axis_tlast;       // last_of_block
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // predictor state
  logic [RATIO_CFG_W-1:0] cfg_ratio_w = 4'd2;
  logic [RATIO_CFG_W-1:0] cfg_ratio_h = 4'd2;
  logic [SENS_W-1:0]      cfg_sens = 16'd256;
  logic [PIX_W-1:0]       blk_buf [BUF_DEPTH];
  longint                 blk_sum = 0;
  int                     blk_fill = 0;
  enh_pix_t               enhanced_q [$];

  int          mismatches = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned cycle_cnt = 0;
  sink_mode_e  sink_mode = SINK_OPEN;
  int          sink_left = 0;

  block_intensity_detail_transfer #(
    .MAX_RATIO(MAX_RATIO_DEF)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_ratio(logic [RATIO_CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_RATIO_DEF) return MAX_RATIO_DEF;
    return int'(r);
  endfunction

  function automatic int block_len();
    return eff_ratio(cfg_ratio_w) * eff_ratio(cfg_ratio_h);
  endfunction

  // low * (S*s + 256*(high*n - S)) / (S*s), rounded half up, clamped
  function automatic logic [PIX_W-1:0] enhance_pixel(logic [PIX_W-1:0] high,
                                                     logic [PIX_W-1:0] low, longint n);
    longint s;
    longint den;
    longint inner;
    longint num;
    longint q;
    if (blk_sum == 0) return (low > PIX_MAX) ? PIX_MAX : low;
    s = (cfg_sens == 0) ? 64'sd1 : longint'(cfg_sens);
    den = blk_sum * s;
    inner = den + 256 * (longint'(high) * n - blk_sum);
    num = longint'(low) * inner;
    if (num <= 0) return '0;
    q = (num * 2 + den) / (den * 2);
    return (q > longint'(PIX_MAX)) ? PIX_MAX : q[PIX_W-1:0];
  endfunction

  function automatic void absorb_pixel(logic [PIX_W-1:0] high, logic [PIX_W-1:0] low);
    longint   n;
    enh_pix_t e;
    if (blk_fill < BUF_DEPTH) begin
      blk_buf[blk_fill] = high;
      blk_sum += high;
      blk_fill++;
    end
    if (blk_fill < block_len() && blk_fill < BUF_DEPTH) return;
    n = blk_fill;
    for (int k = 0; k < n; k++) begin
      e.pix = enhance_pixel(blk_buf[k], low, n);
      e.last = (k + 1 == n);
      enhanced_q.push_back(e);
    end
    blk_sum = 0;
    blk_fill = 0;
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    enh_pix_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (enhanced_q.size() == 0) begin
        $error("out_pixel: expected no transfer, actual %0d", m_axis_tdata);
        mismatches++;
      end else begin
        want = enhanced_q.pop_front();
        if (m_axis_tdata !== want.pix) begin
          $error("out_pixel: expected %0d, actual %0d", want.pix, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_block: expected %0d, actual %0d", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // sink alternates between always ready, coin flips and heavy throttling
  always @(negedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(2, 0));
      sink_left = $urandom_range(300, 40);
    end
    sink_left--;
    case (sink_mode)
      SINK_OPEN:     m_axis_tready = 1'b1;
      SINK_COIN:     m_axis_tready = 1'($urandom_range(1, 0));
      SINK_THROTTLE: m_axis_tready = ($urandom_range(5, 0) == 0);
      default:       m_axis_tready = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_pixel(logic [PIX_W-1:0] high, logic [PIX_W-1:0] low);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = gaps_on ? $urandom_range(4, 0) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {low, high};
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_pixel(high, low);
  endtask

  // source idle until every pending pixel is out, then a quiet stretch
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (enhanced_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_RATIO_W: cfg_ratio_w = val[RATIO_CFG_W-1:0];
      REG_RATIO_H: cfg_ratio_h = val[RATIO_CFG_W-1:0];
      REG_SENS:    cfg_sens = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // unused upper data bits carry noise
  task automatic set_ratios(int w, int h);
    logic [11:0] junk;
    junk = $urandom_range(4095, 0);
    write_reg(REG_RATIO_W, {junk, 4'(w)});
    junk = $urandom_range(4095, 0);
    write_reg(REG_RATIO_H, {junk, 4'(h)});
  endtask

  task automatic send_block(int count);
    blk_kind_e        kind;
    int               base;
    int               h;
    logic [PIX_W-1:0] lo;
    kind = blk_kind_e'($urandom_range(4, 0));
    base = $urandom_range(65000, 16);
    for (int i = 0; i < count; i++) begin
      case (kind)
        BLK_FLAT:  h = base + $urandom_range(32, 0) - 16;
        BLK_ZERO:  h = 0;
        BLK_EDGES: h = $urandom_range(1, 0) ? 65535 : 0;
        BLK_DARK:  h = $urandom_range(15, 0);
        default:   h = $urandom_range(65535, 0);
      endcase
      lo = $urandom_range(65535, 0);
      if (i == count - 1) begin
        case ($urandom_range(3, 0))
          0: lo = '0;
          1: lo = PIX_MAX;
          default: ;
        endcase
      end
      send_pixel(h[PIX_W-1:0], lo);
    end
  endtask

  function automatic int pick_ratio();
    if ($urandom_range(4, 0) == 0) return $urandom_range(15, 0);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [SENS_W-1:0] pick_sens();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'd256;
      4: return SENS_W'($urandom_range(64, 1));
      default: return SENS_W'($urandom_range(65535, 0));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // 2x2 at unity sensitivity: zero pixel, saturating pixel
  task automatic test_reset_defaults();
    send_pixel(16'd0, 16'd777);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'd100, 16'd0);
    send_pixel(16'd30000, 16'hFFFF);
  endtask

  // single pixel blocks, width register zero acts as one
  task automatic test_zero_sum();
    settle();
    set_ratios(0, 1);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_zero_sensitivity();
    settle();
    set_ratios(2, 0);
    write_reg(REG_SENS, '0);
    send_pixel(16'd1000, 16'd5);
    send_pixel(16'd3000, 16'd40000);
    send_pixel(16'd0, 16'd9);
    send_pixel(16'hFFFF, 16'hFFFF);
  endtask

  // shrink the block while part of it is loaded
  task automatic test_ratio_change_mid_block();
    settle();
    set_ratios(4, 4);
    write_reg(REG_SENS, 16'hFFFF);
    send_block(5);
    settle();
    set_ratios(1, 1);
    send_pixel(16'($urandom_range(65535, 0)), 16'hFFFF);
  endtask

  task automatic test_ratio_above_max();
    settle();
    set_ratios(15, 1);
    write_reg(REG_SENS, 16'd1);
    send_block(block_len());
  endtask

  task automatic test_random_blocks();
    int sent;
    int phase;
    int phase_end;
    int len;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      if (phase == 1) set_ratios(8, 15);
      else set_ratios(pick_ratio(), pick_ratio());
      write_reg(REG_SENS, pick_sens());
      gaps_on = ($urandom_range(3, 0) != 0);
      phase_end = sent + $urandom_range(60, 20);
      while (sent < phase_end) begin
        len = block_len();
        send_block(len);
        sent += len;
      end
      // leave a partial block behind for the next setting
      if ($urandom_range(4, 0) == 0 && block_len() > 1) begin
        len = $urandom_range(block_len() - 1, 1);
        send_block(len);
        sent += len;
      end
      phase++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_zero_sum();
    test_zero_sensitivity();
    test_ratio_change_mid_block();
    test_ratio_above_max();
    test_random_blocks();
    settle();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: block_intensity_detail_transfer.f
+incdir+src
src/bidt_pkg.sv
src/bidt_ram.sv
src/bidt_div.sv
src/block_intensity_detail_transfer.sv
verif/testbench.sv
